FILE: design/vllr_pkg.sv
// ----------------------------------------------------------------------------
// vllr_pkg
// Shared types, register map and interpolation tables for the voxel
// log-likelihood reducer.
// ----------------------------------------------------------------------------
package vllr_pkg;

    localparam int EXP_TABLE_SIZE = 256;
    localparam int LOG_TABLE_SIZE = 256;
    localparam int EXP_IW         = $clog2(EXP_TABLE_SIZE);
    localparam int LOG_IW         = $clog2(LOG_TABLE_SIZE);
    localparam int EXP_IDX_SHIFT  = 21 - EXP_IW;

    localparam logic [24:0] COUNT_CAP = 25'd16777216;

    localparam logic [2:0] REG_PET_SCALE    = 3'd0;
    localparam logic [2:0] REG_HALF_INV_VAR = 3'd1;
    localparam logic [2:0] REG_LOG_NORM     = 3'd2;
    localparam logic [2:0] REG_INV_SLOPE    = 3'd3;
    localparam logic [2:0] REG_T1_THRESHOLD = 3'd4;
    localparam logic [2:0] REG_T2_THRESHOLD = 3'd5;

    typedef struct packed {
        logic signed [31:0] pet_scale;
        logic [30:0]        pet_half_inv_var;
        logic signed [31:0] pet_log_norm;
        logic [30:0]        inv_slope;
        logic signed [31:0] t1_threshold;
        logic signed [31:0] t2_threshold;
    } t_cfg;

    typedef struct packed {
        logic signed [31:0] model_value;
        logic signed [31:0] pet_value;
        logic               t1_marked;
        logic               flair_marked;
        logic               is_last;
        logic               pet_pos;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_queue_head;

    typedef logic [31:0] t_exp_tab [0:EXP_TABLE_SIZE];
    typedef logic [31:0] t_log_tab [0:LOG_TABLE_SIZE];

    localparam logic [63:0] ONE31 = 64'h8000_0000;

    function automatic logic [63:0] f_udiv(input logic [63:0] n, input logic [63:0] d);
        logic [63:0] q;
        logic [63:0] r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[62:0], n[b]};
            if (r >= d) begin
                r    = r - d;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic [63:0] f_exp_series(input logic [63:0] f);
        logic signed [63:0] acc;
        logic [63:0]        term;
        acc  = ONE31;
        term = ONE31;
        for (int k = 1; k <= 24; k++) begin
            term = f_udiv((term * f) >> 31, 64'(k));
            if (k % 2 == 1) acc = acc - $signed(term);
            else            acc = acc + $signed(term);
        end
        if (acc < 0) acc = 0;
        if (acc > $signed(ONE31)) acc = $signed(ONE31);
        return acc;
    endfunction

    function automatic t_exp_tab f_build_exp();
        t_exp_tab    tab;
        logic [63:0] e1, num, whole, f, v;
        e1 = f_exp_series(ONE31);
        for (int k = 0; k <= EXP_TABLE_SIZE; k++) begin
            num   = 64'(k) * 64'd32;
            whole = num / EXP_TABLE_SIZE;
            f     = ((num % EXP_TABLE_SIZE) << 31) / EXP_TABLE_SIZE;
            v     = f_exp_series(f);
            for (int j = 0; j < 64; j++) begin
                if (64'(j) < whole) v = (v * e1) >> 31;
            end
            tab[k] = v[31:0];
        end
        return tab;
    endfunction

    function automatic t_log_tab f_build_log();
        t_log_tab    tab;
        logic [63:0] z, zz, pw, acc;
        for (int k = 0; k <= LOG_TABLE_SIZE; k++) begin
            z   = f_udiv(64'(k) << 31, 64'(2 * LOG_TABLE_SIZE) + 64'(k));
            zz  = (z * z) >> 31;
            pw  = z;
            acc = 0;
            for (int j = 0; j < 24; j++) begin
                acc = acc + f_udiv(pw, 64'(2 * j + 1));
                pw  = (pw * zz) >> 31;
            end
            tab[k] = 32'(2 * acc);
        end
        return tab;
    endfunction

    localparam t_exp_tab EXP_TAB = f_build_exp();
    localparam t_log_tab LOG_TAB = f_build_log();

endpackage

FILE: design/vllr_if.sv
// ----------------------------------------------------------------------------
// vllr_in_if / vllr_out_if
// Valid/ready channels for voxel items and likelihood results.
// ----------------------------------------------------------------------------
interface vllr_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] model_value;
    logic signed [31:0] pet_value;
    logic               t1_marked;
    logic               flair_marked;
    logic               is_last;

    modport source (output valid, model_value, pet_value, t1_marked, flair_marked,
                    is_last, input ready);
    modport sink   (input valid, model_value, pet_value, t1_marked, flair_marked,
                    is_last, output ready);
endinterface

interface vllr_out_if;
    logic               valid;
    logic               ready;
    logic signed [63:0] neg_log_likelihood;
    logic [24:0]        pet_count;

    modport source (output valid, neg_log_likelihood, pet_count, input ready);
    modport sink   (input valid, neg_log_likelihood, pet_count, output ready);
endinterface

FILE: design/voxel_log_likelihood_reduce_top.sv
// The back end takes one voxel at a time from the queue head; a voxel with
// positive PET adds the residual-square steps, a term of zero probability skips
// the log steps, a last voxel adds the final steps; all share one 33x33 multiplier.
// A two-entry queue takes new voxels while the back end works.
// Reset is synchronous, active low; it clears sums, count, queue and result
// valid and loads the register defaults.
// ----------------------------------------------------------------------------
// voxel_log_likelihood_reduce_top
// Voxel log-likelihood reducer: APB registers, front queue, back sequencer.
// ----------------------------------------------------------------------------
module voxel_log_likelihood_reduce_top
    import vllr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    vllr_in_if.sink     i_item,
    vllr_out_if.source  o_result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_cfg        r_cfg, n_cfg;
    t_queue_head w_head;
    logic        w_pop;
    logic        wr_en;
    logic [2:0]  reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];

    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            case (reg_idx)
                REG_PET_SCALE:    n_cfg.pet_scale        = pwdata;
                REG_HALF_INV_VAR: n_cfg.pet_half_inv_var = pwdata[30:0];
                REG_LOG_NORM:     n_cfg.pet_log_norm     = pwdata;
                REG_INV_SLOPE:    n_cfg.inv_slope        = pwdata[30:0];
                REG_T1_THRESHOLD: n_cfg.t1_threshold     = pwdata;
                REG_T2_THRESHOLD: n_cfg.t2_threshold     = pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_PET_SCALE:    prdata = r_cfg.pet_scale;
            REG_HALF_INV_VAR: prdata = {1'b0, r_cfg.pet_half_inv_var};
            REG_LOG_NORM:     prdata = r_cfg.pet_log_norm;
            REG_INV_SLOPE:    prdata = {1'b0, r_cfg.inv_slope};
            REG_T1_THRESHOLD: prdata = r_cfg.t1_threshold;
            REG_T2_THRESHOLD: prdata = r_cfg.t2_threshold;
            default:          prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pet_scale        <= 32'sd65536;
            r_cfg.pet_half_inv_var <= 31'd32768;
            r_cfg.pet_log_norm     <= 32'sd60223;
            r_cfg.inv_slope        <= 31'd65536;
            r_cfg.t1_threshold     <= 32'sd0;
            r_cfg.t2_threshold     <= 32'sd0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    vllr_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_item),
        .o_head  (w_head),
        .i_pop   (w_pop)
    );

    vllr_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_head   (w_head),
        .o_pop    (w_pop),
        .o_result (o_result)
    );

endmodule

FILE: design/vllr_front.sv
// ----------------------------------------------------------------------------
// vllr_front
// Accepts voxel items, tags positive PET, and queues them for the back end.
// ----------------------------------------------------------------------------
module vllr_front
    import vllr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    vllr_in_if.sink     i_item,
    output t_queue_head o_head,
    input  logic        i_pop
);

    t_item       r_mem [0:1];
    logic        r_wptr, r_rptr;
    logic [1:0]  r_cnt;
    logic        n_wptr, n_rptr;
    logic [1:0]  n_cnt;
    logic        push;
    t_item       w_item;

    assign i_item.ready = (r_cnt != 2'd2);
    assign push         = i_item.valid && i_item.ready;

    always_comb begin
        w_item.model_value  = i_item.model_value;
        w_item.pet_value    = i_item.pet_value;
        w_item.t1_marked    = i_item.t1_marked;
        w_item.flair_marked = i_item.flair_marked;
        w_item.is_last      = i_item.is_last;
        w_item.pet_pos      = !i_item.pet_value[31] && (i_item.pet_value != 32'sd0);
    end

    assign n_wptr = push ? !r_wptr : r_wptr;
    assign n_rptr = i_pop ? !r_rptr : r_rptr;
    assign n_cnt  = r_cnt + {1'b0, push} - {1'b0, i_pop};

    assign o_head.valid = (r_cnt != 2'd0);
    assign o_head.item  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= w_item;
        end
    end

endmodule

FILE: design/vllr_back.sv
// ----------------------------------------------------------------------------
// vllr_back
// Sequencer around one shared 33x33 multiplier: residual square, two
// segmentation log terms, accumulation and the final likelihood.
// ----------------------------------------------------------------------------
module vllr_back
    import vllr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  t_queue_head i_head,
    output logic        o_pop,
    vllr_out_if.source  o_result
);

    localparam logic [4:0] ST_IDLE  = 5'd0;
    localparam logic [4:0] ST_SQ_A  = 5'd1;
    localparam logic [4:0] ST_SQ_B  = 5'd2;
    localparam logic [4:0] ST_SQ_C  = 5'd3;
    localparam logic [4:0] ST_SQ_D  = 5'd4;
    localparam logic [4:0] ST_SEG_A = 5'd5;
    localparam logic [4:0] ST_SEG_B = 5'd6;
    localparam logic [4:0] ST_SEG_C = 5'd7;
    localparam logic [4:0] ST_SEG_D = 5'd8;
    localparam logic [4:0] ST_SEG_E = 5'd9;
    localparam logic [4:0] ST_SEG_F = 5'd10;
    localparam logic [4:0] ST_NORM  = 5'd11;
    localparam logic [4:0] ST_LOG_A = 5'd12;
    localparam logic [4:0] ST_LOG_B = 5'd13;
    localparam logic [4:0] ST_LOG_C = 5'd14;
    localparam logic [4:0] ST_FIN_A = 5'd15;
    localparam logic [4:0] ST_FIN_B = 5'd16;
    localparam logic [4:0] ST_FIN_C = 5'd17;
    localparam logic [4:0] ST_FIN_D = 5'd18;
    localparam logic [4:0] ST_FIN_E = 5'd19;

    localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;
    localparam logic [21:0]        E_CAP   = 22'h20_0000;

    function automatic logic signed [63:0] f_sat_add(input logic signed [63:0] a,
                                                     input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
        return s[63:0];
    endfunction

    function automatic logic signed [63:0] f_sat_sub(input logic signed [63:0] a,
                                                     input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} - {b[63], b};
        if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
        return s[63:0];
    endfunction

    logic [4:0]         r_state, n_state;
    logic               r_seg, n_seg;
    logic [2:0]         r_step, n_step;
    t_item              r_it, n_it;
    logic signed [65:0] r_prod;
    logic signed [32:0] n_ma, n_mb;
    logic [47:0]        r_ar, n_ar;
    logic               r_dpos, n_dpos;
    logic [47:0]        r_d2, n_d2;
    logic [36:0]        r_hi, n_hi;
    logic [21:0]        r_e, n_e;
    logic [31:0]        r_ta, n_ta;
    logic               r_ge, n_ge;
    logic               r_ez, n_ez;
    logic [31:0]        r_p, n_p;
    logic [4:0]         r_s, n_s;
    logic [31:0]        r_lv, n_lv;
    logic signed [63:0] r_res, n_res;
    logic [63:0]        r_plo, n_plo;
    logic [63:0]        r_sqsum, n_sqsum;
    logic [24:0]        r_cnt, n_cnt;
    logic signed [63:0] r_log1, n_log1;
    logic signed [63:0] r_log2, n_log2;
    logic               r_ov, n_ov;
    logic signed [63:0] r_onll, n_onll;
    logic [24:0]        r_ocnt, n_ocnt;

    logic signed [31:0] thr;
    logic signed [32:0] dval;
    logic [32:0]        dneg;
    logic signed [63:0] resid;
    logic [63:0]        rabs;
    logic [68:0]        efull;
    logic [52:0]        eshr;
    logic [EXP_IW:0]    eix, eixp;
    logic [31:0]        ea, eb;
    logic [20:0]        efrac;
    logic [31:0]        exv, hv, av, pv;
    logic [LOG_IW:0]    lix, lixp;
    logic [31:0]        la, lb;
    logic [30:0]        lfrac;
    logic signed [63:0] lval;
    logic signed [63:0] lacc;
    logic signed [63:0] nprod;
    logic [63:0]        tq;
    logic signed [63:0] quad;
    logic signed [63:0] fres;
    logic               cur_flag;

    assign o_result.valid              = r_ov;
    assign o_result.neg_log_likelihood = r_onll;
    assign o_result.pet_count          = r_ocnt;

    assign thr   = r_seg ? i_cfg.t2_threshold : i_cfg.t1_threshold;
    assign dval  = {r_it.model_value[31], r_it.model_value} - {thr[31], thr};
    assign dneg  = 33'd0 - dval;
    assign resid = {{16{r_it.model_value[31]}}, r_it.model_value, 16'd0} - r_prod[63:0];
    assign rabs  = resid[63] ? (64'd0 - resid) : resid;
    assign efull = {r_hi, 32'd0} + {5'd0, r_prod[63:0]};
    assign eshr  = efull[68:16];

    assign eix   = {1'b0, r_e[EXP_IDX_SHIFT +: EXP_IW]};
    assign eixp  = eix + 1'b1;
    assign ea    = EXP_TAB[eix];
    assign eb    = EXP_TAB[eixp];
    assign efrac = {r_e[EXP_IDX_SHIFT-1:0], {EXP_IW{1'b0}}};

    assign exv   = r_ez ? 32'd0 : (r_ge ? r_ta + r_prod[52:21] : r_ta - r_prod[52:21]);
    assign hv    = exv >> 1;
    assign cur_flag = r_seg ? r_it.flair_marked : r_it.t1_marked;
    assign av    = r_dpos ? (ONE31[31:0] - hv) : hv;
    assign pv    = cur_flag ? av : (ONE31[31:0] - av);

    assign lix   = {1'b0, r_p[30 -: LOG_IW]};
    assign lixp  = lix + 1'b1;
    assign la    = LOG_TAB[lix];
    assign lb    = LOG_TAB[lixp];
    assign lfrac = {r_p[30-LOG_IW:0], {LOG_IW{1'b0}}};

    assign lval  = $signed({32'd0, r_lv}) - r_prod[63:0];
    assign lacc  = f_sat_add(r_seg ? r_log2 : r_log1, lval <<< 1);

    assign nprod = r_prod[63:0];
    assign tq    = (r_prod[63:0] << 16) + (r_plo >> 16);
    assign quad  = (r_prod[63:0] >= 64'h0000_8000_0000_0000 || tq[63]) ? S64_MAX : tq;
    assign fres  = f_sat_sub(f_sat_sub(r_res, r_log1), r_log2);

    assign o_pop = (r_state == ST_IDLE) && i_head.valid;

    always_comb begin
        n_state = r_state;
        n_seg   = r_seg;
        n_step  = r_step;
        n_it    = r_it;
        n_ma    = 33'sd0;
        n_mb    = 33'sd0;
        n_ar    = r_ar;
        n_dpos  = r_dpos;
        n_d2    = r_d2;
        n_hi    = r_hi;
        n_e     = r_e;
        n_ta    = r_ta;
        n_ge    = r_ge;
        n_ez    = r_ez;
        n_p     = r_p;
        n_s     = r_s;
        n_lv    = r_lv;
        n_res   = r_res;
        n_plo   = r_plo;
        n_sqsum = r_sqsum;
        n_cnt   = r_cnt;
        n_log1  = r_log1;
        n_log2  = r_log2;
        n_ov    = r_ov && !o_result.ready;
        n_onll  = r_onll;
        n_ocnt  = r_ocnt;

        case (r_state)
            ST_IDLE: begin
                if (i_head.valid) begin
                    n_it    = i_head.item;
                    n_seg   = 1'b0;
                    n_state = i_head.item.pet_pos ? ST_SQ_A : ST_SEG_A;
                end
            end
            ST_SQ_A: begin
                n_ma    = {i_cfg.pet_scale[31], i_cfg.pet_scale};
                n_mb    = {r_it.pet_value[31], r_it.pet_value};
                n_state = ST_SQ_B;
            end
            ST_SQ_B: begin
                n_ar    = rabs[63:16];
                n_state = ST_SQ_C;
            end
            ST_SQ_C: begin
                n_ma    = {1'b0, r_ar[31:0]};
                n_mb    = {1'b0, r_ar[31:0]};
                n_state = ST_SQ_D;
            end
            ST_SQ_D: begin
                if (r_ar[47:32] != 16'd0) begin
                    n_sqsum = '1;
                end else if (r_sqsum > ~r_prod[63:0]) begin
                    n_sqsum = '1;
                end else begin
                    n_sqsum = r_sqsum + r_prod[63:0];
                end
                if (r_cnt < COUNT_CAP) n_cnt = r_cnt + 25'd1;
                n_state = ST_SEG_A;
            end
            ST_SEG_A: begin
                n_dpos  = !dval[32] && (dval != 33'sd0);
                n_ma    = {1'b0, dneg[31:0]};
                n_mb    = {1'b0, dneg[31:0]};
                n_state = ST_SEG_B;
            end
            ST_SEG_B: begin
                n_d2    = r_prod[63:16];
                n_ma    = {27'd0, r_prod[53:48]};
                n_mb    = {2'b0, i_cfg.inv_slope};
                n_state = ST_SEG_C;
            end
            ST_SEG_C: begin
                n_hi    = r_prod[36:0];
                n_ma    = {1'b0, r_d2[31:0]};
                n_mb    = {2'b0, i_cfg.inv_slope};
                n_state = ST_SEG_D;
            end
            ST_SEG_D: begin
                if (r_dpos) begin
                    n_e = ({1'b0, i_cfg.inv_slope} < {10'd0, E_CAP}) ?
                          i_cfg.inv_slope[21:0] : E_CAP;
                end else if (i_cfg.inv_slope == 31'd0) begin
                    n_e = 22'd0;
                end else if (r_d2[47:38] != 10'd0) begin
                    n_e = E_CAP;
                end else begin
                    n_e = (eshr > {31'd0, E_CAP}) ? E_CAP : eshr[21:0];
                end
                n_state = ST_SEG_E;
            end
            ST_SEG_E: begin
                n_ez    = r_e[21];
                n_ta    = ea;
                n_ge    = (eb >= ea);
                n_ma    = {1'b0, (eb >= ea) ? (eb - ea) : (ea - eb)};
                n_mb    = {12'd0, efrac};
                n_state = ST_SEG_F;
            end
            ST_SEG_F: begin
                n_p    = pv;
                n_s    = 5'd0;
                n_step = 3'd0;
                if (pv == 32'd0) begin
                    if (r_seg) n_log2 = S64_MIN;
                    else       n_log1 = S64_MIN;
                    n_seg   = 1'b1;
                    n_state = r_seg ? (r_it.is_last ? ST_FIN_A : ST_IDLE) : ST_SEG_A;
                end else begin
                    n_state = ST_NORM;
                end
            end
            ST_NORM: begin
                case (r_step)
                    3'd0: if (r_p[31:16] == 16'd0) begin
                        n_p = r_p << 16;
                        n_s = r_s + 5'd16;
                    end
                    3'd1: if (r_p[31:24] == 8'd0) begin
                        n_p = r_p << 8;
                        n_s = r_s + 5'd8;
                    end
                    3'd2: if (r_p[31:28] == 4'd0) begin
                        n_p = r_p << 4;
                        n_s = r_s + 5'd4;
                    end
                    3'd3: if (r_p[31:30] == 2'd0) begin
                        n_p = r_p << 2;
                        n_s = r_s + 5'd2;
                    end
                    3'd4: if (!r_p[31]) begin
                        n_p = r_p << 1;
                        n_s = r_s + 5'd1;
                    end
                    default: ;
                endcase
                n_step = r_step + 3'd1;
                if (r_step == 3'd4) n_state = ST_LOG_A;
            end
            ST_LOG_A: begin
                n_ta    = la;
                n_ge    = (lb >= la);
                n_ma    = {1'b0, (lb >= la) ? (lb - la) : (la - lb)};
                n_mb    = {2'b0, lfrac};
                n_state = ST_LOG_B;
            end
            ST_LOG_B: begin
                n_lv    = r_ge ? r_ta + r_prod[62:31] : r_ta - r_prod[62:31];
                n_ma    = {28'd0, r_s};
                n_mb    = {1'b0, LOG_TAB[LOG_TABLE_SIZE]};
                n_state = ST_LOG_C;
            end
            ST_LOG_C: begin
                if (r_seg) n_log2 = lacc;
                else       n_log1 = lacc;
                n_seg   = 1'b1;
                n_state = r_seg ? (r_it.is_last ? ST_FIN_A : ST_IDLE) : ST_SEG_A;
            end
            ST_FIN_A: begin
                n_ma    = {8'd0, r_cnt};
                n_mb    = {i_cfg.pet_log_norm[31], i_cfg.pet_log_norm};
                n_state = ST_FIN_B;
            end
            ST_FIN_B: begin
                if (nprod > 64'sh0000_7FFF_FFFF_FFFF)       n_res = S64_MAX;
                else if (nprod < -64'sh0000_8000_0000_0000) n_res = S64_MIN;
                else                                        n_res = nprod <<< 16;
                n_ma    = {1'b0, r_sqsum[31:0]};
                n_mb    = {2'b0, i_cfg.pet_half_inv_var};
                n_state = ST_FIN_C;
            end
            ST_FIN_C: begin
                n_plo   = r_prod[63:0];
                n_ma    = {1'b0, r_sqsum[63:32]};
                n_mb    = {2'b0, i_cfg.pet_half_inv_var};
                n_state = ST_FIN_D;
            end
            ST_FIN_D: begin
                n_res   = f_sat_add(r_res, quad);
                n_state = ST_FIN_E;
            end
            ST_FIN_E: begin
                if (!r_ov || o_result.ready) begin
                    n_ov    = 1'b1;
                    n_onll  = fres;
                    n_ocnt  = r_cnt;
                    n_sqsum = 64'd0;
                    n_cnt   = 25'd0;
                    n_log1  = 64'sd0;
                    n_log2  = 64'sd0;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_seg   <= 1'b0;
            r_step  <= 3'd0;
            r_sqsum <= 64'd0;
            r_cnt   <= 25'd0;
            r_log1  <= 64'sd0;
            r_log2  <= 64'sd0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_seg   <= n_seg;
            r_step  <= n_step;
            r_sqsum <= n_sqsum;
            r_cnt   <= n_cnt;
            r_log1  <= n_log1;
            r_log2  <= n_log2;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_it   <= n_it;
        r_prod <= n_ma * n_mb;
        r_ar   <= n_ar;
        r_dpos <= n_dpos;
        r_d2   <= n_d2;
        r_hi   <= n_hi;
        r_e    <= n_e;
        r_ta   <= n_ta;
        r_ge   <= n_ge;
        r_ez   <= n_ez;
        r_p    <= n_p;
        r_s    <= n_s;
        r_lv   <= n_lv;
        r_res  <= n_res;
        r_plo  <= n_plo;
        r_onll <= n_onll;
        r_ocnt <= n_ocnt;
    end

endmodule

FILE: design/vllr_chk.sv
// ----------------------------------------------------------------------------
// vllr_chk
// Port-level checks on the result channel and the APB ready of the reducer.
// ----------------------------------------------------------------------------
module vllr_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [63:0] i_out_nll,
    input logic [24:0] i_out_cnt,
    input logic        i_pready
);

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_cnt <= 25'd16777216))
        else $error("count beyond cap");

    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped before transfer");

    a_payload_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_nll) && $stable(i_out_cnt))
        else $error("result changed before transfer");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pready)
        else $error("apb wait state");

endmodule

bind voxel_log_likelihood_reduce_top vllr_chk u_vllr_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_out_nll   (o_result.neg_log_likelihood),
    .i_out_cnt   (o_result.pet_count),
    .i_pready    (pready)
);
